[rtl/core/dbgrl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dbgrl_pkg: shared types and constants for the dual button gesture detector
// Holds the item structs, event codes, register indexes, ring modes, reset values, blink timing and timer limits.
// ----------------------------------------------------------------------------
package dbgrl_pkg;

	// Blink timing in ticks
	localparam int unsigned BLINK_PERIOD = 50;
	localparam int unsigned BLINK_LIT    = 25;
	localparam int unsigned BLINK_W      = 6;

	// Timer widths and limits
	localparam int unsigned HOLD_W  = 21;
	localparam int unsigned QUIET_W = 17;
	localparam logic signed [HOLD_W-1:0] HOLD_MAX  = 21'sd1048575;
	localparam logic signed [HOLD_W-1:0] LONG_MARK = -21'sd1000000;
	localparam logic [QUIET_W-1:0]       QUIET_MAX = 17'd131071;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_RING_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING_BLINK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_MS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_SETTLE = 3'd4;

	// Ring modes
	localparam logic [2:0] RING_AUTO       = 3'd0;
	localparam logic [2:0] RING_ON         = 3'd1;
	localparam logic [2:0] RING_OFF        = 3'd2;
	localparam logic [2:0] RING_ON_OPEN    = 3'd3;
	localparam logic [2:0] RING_OFF_CLOSED = 3'd4;

	// Register reset values
	localparam logic [2:0]  RST_RING_MODE    = RING_AUTO;
	localparam logic        RST_RING_BLINK   = 1'b1;
	localparam logic [7:0]  RST_POLL_MS      = 8'd10;
	localparam logic [15:0] RST_LONG_PRESS   = 16'd2999;
	localparam logic [15:0] RST_CLICK_SETTLE = 16'd300;

	typedef enum logic [1:0] {
		EVT_NONE  = 2'd0,
		EVT_LONG  = 2'd1,
		EVT_CLICK = 2'd2
	} evt_t;

	typedef struct packed {
		logic user_pressed;
		logic boot_pressed;
		logic manual_mode;
		logic vent_is_open;
	} tick_t;

	typedef struct packed {
		logic led_on;
		evt_t user_event;
		evt_t boot_event;
	} result_t;

	typedef struct packed {
		logic signed [HOLD_W-1:0] hold;
		logic [QUIET_W-1:0]       quiet;
		logic                     pending;
		logic                     armed;
	} btn_state_t;

endpackage : dbgrl_pkg
`default_nettype wire

[rtl/core/dual_button_gesture_ring_led_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dual_button_gesture_ring_led_top: two-button gesture detector and ring LED
// Turns per-tick button levels into long-press and click events and an LED level.
// ----------------------------------------------------------------------------
// Usage:
//   Send one item per poll tick on the tick channel (tick_valid / tick_stall).
//   Each item yields exactly one result on the result channel (result_valid /
//   result_stall): the ring LED level and one event code per button.
//   An accepted item lands in the input register; once the result register is free,
//   its result is computed from the button state and stored in the result register.
//   Throughput is one item per cycle while the receiver does not stall; the button
//   and blink state update in the same cycle the result register loads.
//   When the receiver stalls, the result register holds, the input register
//   fills, and tick_stall rises until the result is taken.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user must keep
//   writes to times when no item is in flight (the block does not check); an unknown index is ignored.
//   Reset clears the timers, flags, blink counter and both channel valids, and
//   loads the registers with their default values.
// ----------------------------------------------------------------------------
module dual_button_gesture_ring_led_top
	import dbgrl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tick_valid,
	output logic                       tick_stall,
	input  wire tick_t                 tick,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [2:0]  ring_mode_q;
	logic        ring_blink_q;
	logic [7:0]  poll_ms_q;
	logic [15:0] long_press_q;
	logic [15:0] click_settle_q;

	// Pipeline and state
	logic               valid_s1;
	tick_t              tick_s1;
	logic               res_valid_q;
	result_t            res_q;
	logic [BLINK_W-1:0] blink_q;
	btn_state_t         user_q;
	btn_state_t         boot_q;

	logic               out_free;
	logic               advance;
	logic [BLINK_W-1:0] blink_inc;
	logic [BLINK_W-1:0] blink_nxt;
	logic               base_led;
	logic               led_nxt;
	btn_state_t         user_nxt;
	btn_state_t         boot_nxt;
	evt_t               user_evt;
	evt_t               boot_evt;

	// One button tick: arm on release, time the hold and the quiet window
	function automatic void btn_step(
		input  btn_state_t  cur,
		input  logic        down,
		input  logic        guard_long,
		input  logic [7:0]  poll,
		input  logic [15:0] long_ms,
		input  logic [15:0] settle_ms,
		output btn_state_t  nxt,
		output evt_t        evt
	);
		logic signed [HOLD_W:0] h_sum;
		logic signed [HOLD_W-1:0] h_sat;
		logic [QUIET_W-1:0] q_base;
		logic [QUIET_W:0]   q_sum;
		logic [QUIET_W-1:0] q_sat;
		logic               pend;
		logic               held;
		nxt   = cur;
		evt   = EVT_NONE;
		h_sum = $signed({cur.hold[HOLD_W-1], cur.hold}) + $signed({14'd0, poll});
		h_sat = (h_sum > $signed({1'b0, HOLD_MAX})) ? HOLD_MAX : h_sum[HOLD_W-1:0];
		held  = cur.hold > $signed({HOLD_W{1'b0}});
		pend  = cur.pending | held;
		q_base = held ? '0 : cur.quiet;
		q_sum = {1'b0, q_base} + {10'd0, poll};
		q_sat = (q_sum > {1'b0, QUIET_MAX}) ? QUIET_MAX : q_sum[QUIET_W-1:0];
		nxt.armed = cur.armed | ~down;
		if (nxt.armed) begin
			if (down) begin
				nxt.quiet = '0;
				if ((h_sat > $signed({5'd0, long_ms})) && !(guard_long && cur.pending)) begin
					nxt.pending = 1'b0;
					nxt.hold    = LONG_MARK;
					evt         = EVT_LONG;
				end else begin
					nxt.hold = h_sat;
				end
			end else begin
				nxt.hold    = '0;
				nxt.pending = pend;
				nxt.quiet   = q_base;
				if (pend) begin
					if (q_sat > {1'b0, settle_ms}) begin
						nxt.pending = 1'b0;
						nxt.quiet   = '0;
						evt         = EVT_CLICK;
					end else begin
						nxt.quiet = q_sat;
					end
				end
			end
		end
	endfunction

	// Handshake: the result register frees when empty or taken
	assign out_free     = !res_valid_q || !result_stall;
	assign advance      = valid_s1 && out_free;
	assign tick_stall   = valid_s1 && !out_free;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Advance the blink counter and pick the LED level
	always_comb begin
		blink_inc = blink_q + 1'b1;
		blink_nxt = (blink_inc >= BLINK_W'(BLINK_PERIOD)) ? '0 : blink_inc;
		base_led  = 1'b0;
		if (tick_s1.manual_mode) begin
			base_led = ring_blink_q ? (blink_nxt < BLINK_W'(BLINK_LIT)) : 1'b1;
		end
		unique case (ring_mode_q)
			RING_ON:         led_nxt = 1'b1;
			RING_OFF:        led_nxt = 1'b0;
			RING_ON_OPEN:    led_nxt = tick_s1.vent_is_open ? 1'b1 : base_led;
			RING_OFF_CLOSED: led_nxt = tick_s1.vent_is_open ? base_led : 1'b0;
			default:         led_nxt = base_led;
		endcase
	end

	// Step both buttons
	always_comb begin
		btn_step(user_q, tick_s1.user_pressed, 1'b1, poll_ms_q, long_press_q,
			click_settle_q, user_nxt, user_evt);
		btn_step(boot_q, tick_s1.boot_pressed, 1'b0, poll_ms_q, long_press_q,
			click_settle_q, boot_nxt, boot_evt);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_mode_q    <= RST_RING_MODE;
			ring_blink_q   <= RST_RING_BLINK;
			poll_ms_q      <= RST_POLL_MS;
			long_press_q   <= RST_LONG_PRESS;
			click_settle_q <= RST_CLICK_SETTLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RING_MODE:    ring_mode_q    <= cfg_data[2:0];
				REG_RING_BLINK:   ring_blink_q   <= cfg_data[0];
				REG_POLL_MS:      poll_ms_q      <= cfg_data[7:0];
				REG_LONG_PRESS:   long_press_q   <= cfg_data;
				REG_CLICK_SETTLE: click_settle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: take a new item when empty or whenever the current one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid) begin
			tick_s1 <= tick;
		end
	end

	// Result register and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			blink_q     <= '0;
			user_q      <= '0;
			boot_q      <= '0;
		end else begin
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
			if (advance) begin
				blink_q <= blink_nxt;
				user_q  <= user_nxt;
				boot_q  <= boot_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.led_on     <= led_nxt;
			res_q.user_event <= user_evt;
			res_q.boot_event <= boot_evt;
		end
	end

endmodule : dual_button_gesture_ring_led_top
`default_nettype wire

[dv/dual_button_gesture_ring_led_top_tb.sv]
// ----------------------------------------------------------------------------
// dual_button_gesture_ring_led_top_tb: self-checking bench for the gesture block
// Drives poll ticks through the valid/stall channel and predicts every result
// from a cycle-free model of the blink counter and both button timers. Each
// result is compared field by field. Directed tests come first, then a long
// hold soak, then random gesture scripts over many register settings.
// ----------------------------------------------------------------------------
module dual_button_gesture_ring_led_top_tb;
	import dbgrl_pkg::*;

	localparam int HOLD_CAP        = 1048575;
	localparam int HOLD_FIRED_MARK = -1000000;
	localparam int QUIET_CAP       = 131071;
	localparam int SETTLE_CYCLES   = 3;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_ITEMS    = 800;
	localparam int RANDOM_PHASES   = 10;
	localparam int LONG_HOLD_TICKS = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  tick_valid;
	logic                  tick_stall;
	tick_t                 tick;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of registers and state
	logic [2:0]  mode_reg;
	logic        blink_reg;
	int          poll_reg;
	int          long_reg;
	int          settle_reg;
	logic [5:0]  blink_phase;
	btn_state_t  user_btn;
	btn_state_t  boot_btn;

	result_t expected_results[$];

	bit tx_idle_on;
	bit rx_idle_on;
	int holdoff_cycles;
	int cycles;
	int ticks_sent;
	int results_checked;
	int mismatches;
	int reg_writes;
	int user_longs, user_clicks, boot_longs, boot_clicks;

	dual_button_gesture_ring_led_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic reset_model();
		mode_reg    = RST_RING_MODE;
		blink_reg   = RST_RING_BLINK;
		poll_reg    = int'(RST_POLL_MS);
		long_reg    = int'(RST_LONG_PRESS);
		settle_reg  = int'(RST_CLICK_SETTLE);
		blink_phase = '0;
		user_btn    = '0;
		boot_btn    = '0;
	endtask

	// Advance one button by one tick and return its gesture
	task automatic button_step(inout btn_state_t b, input logic down, input logic guard,
			output evt_t ev);
		int h;
		int q;
		ev = EVT_NONE;
		if (!down)
			b.armed = 1'b1;
		if (b.armed) begin
			if (down) begin
				h = int'($signed(b.hold));
				h = h + poll_reg;
				if (h > HOLD_CAP)
					h = HOLD_CAP;
				b.hold  = HOLD_W'(h);
				b.quiet = '0;
				if (h > long_reg && !(guard && b.pending)) begin
					b.pending = 1'b0;
					b.hold    = HOLD_W'(HOLD_FIRED_MARK);
					ev        = EVT_LONG;
				end
			end else begin
				if ($signed(b.hold) > 0) begin
					b.pending = 1'b1;
					b.quiet   = '0;
				end
				b.hold = '0;
				if (b.pending) begin
					q = int'(b.quiet);
					q = q + poll_reg;
					if (q > QUIET_CAP)
						q = QUIET_CAP;
					b.quiet = QUIET_W'(q);
					if (q > settle_reg) begin
						b.pending = 1'b0;
						b.quiet   = '0;
						ev        = EVT_CLICK;
					end
				end
			end
		end
	endtask

	// Work out the LED level and both gestures for one tick
	task automatic predict_tick(input tick_t t, output result_t r);
		logic base;
		evt_t ue;
		evt_t be;
		blink_phase = blink_phase + 6'd1;
		if (blink_phase >= BLINK_PERIOD)
			blink_phase = '0;
		base = 1'b0;
		if (t.manual_mode)
			base = blink_reg ? (blink_phase < BLINK_LIT) : 1'b1;
		case (mode_reg)
			RING_ON:         r.led_on = 1'b1;
			RING_OFF:        r.led_on = 1'b0;
			RING_ON_OPEN:    r.led_on = t.vent_is_open ? 1'b1 : base;
			RING_OFF_CLOSED: r.led_on = t.vent_is_open ? base : 1'b0;
			default:         r.led_on = base;
		endcase
		button_step(user_btn, t.user_pressed, 1'b1, ue);
		button_step(boot_btn, t.boot_pressed, 1'b0, be);
		r.user_event = ue;
		r.boot_event = be;
	endtask

	// Predict every accepted item
	always @(posedge clk) begin : tick_monitor
		result_t r;
		if (arst_n && tick_valid && !tick_stall) begin
			predict_tick(tick, r);
			expected_results.push_back(r);
		end
	end

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding: %p", result);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (result.led_on !== want.led_on) begin
					$error("led_on: expected %0d, actual %0d", want.led_on, result.led_on);
					mismatches++;
				end
				if (result.user_event !== want.user_event) begin
					$error("user_event: expected %0d, actual %0d", want.user_event,
						result.user_event);
					mismatches++;
				end
				if (result.boot_event !== want.boot_event) begin
					$error("boot_event: expected %0d, actual %0d", want.boot_event,
						result.boot_event);
					mismatches++;
				end
				if (want.user_event == EVT_LONG)  user_longs++;
				if (want.user_event == EVT_CLICK) user_clicks++;
				if (want.boot_event == EVT_LONG)  boot_longs++;
				if (want.boot_event == EVT_CLICK) boot_clicks++;
			end
		end
	end

	// Result side: random stall per item, plus an optional long hold-off
	initial begin : result_taker
		int wait_n;
		result_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (holdoff_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (holdoff_cycles) @(posedge clk);
				holdoff_cycles = 0;
			end
			wait_n = rx_idle_on ? $urandom_range(17, 0) : 0;
			if (wait_n > 0) begin
				result_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// Offer one item after a random gap and hold it until taken
	task automatic send_tick(input tick_t t);
		int gap;
		gap = tx_idle_on ? $urandom_range(17, 0) : 0;
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= t;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
		ticks_sent++;
	endtask

	task automatic send_ticks(input tick_t t, input int n);
		repeat (n) send_tick(t);
	endtask

	function automatic tick_t mk_tick(input int u, input int b, input int m, input int o);
		tick_t t;
		t.user_pressed = u[0];
		t.boot_pressed = b[0];
		t.manual_mode  = m[0];
		t.vent_is_open = o[0];
		return t;
	endfunction

	// Block until every result is back and the pipeline is empty
	task automatic drain();
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register while idle and mirror it in the predictor
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		tick_valid <= 1'b0;
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			REG_RING_MODE:    mode_reg   = data[2:0];
			REG_RING_BLINK:   blink_reg  = data[0];
			REG_POLL_MS:      poll_reg   = int'(data[7:0]);
			REG_LONG_PRESS:   long_reg   = int'(data);
			REG_CLICK_SETTLE: settle_reg = int'(data);
			default: ;
		endcase
	endtask

	// Run length that straddles a threshold given in ticks
	function automatic int run_length(int thr);
		int n;
		case ($urandom_range(3, 0))
			0:       n = $urandom_range(3, 1);
			1:       n = thr + $urandom_range(2, 0) - 1;
			2:       n = $urandom_range(2 * thr + 2, 1);
			default: n = $urandom_range(6, 1);
		endcase
		return (n < 1) ? 1 : n;
	endfunction

	// Scripted press/release runs per button, with some noise ticks mixed in
	task automatic run_gestures(input int count);
		logic lvl [2];
		int   left [2];
		int   press_thr;
		int   quiet_thr;
		tick_t t;
		press_thr = (poll_reg == 0) ? 20 : long_reg / poll_reg + 1;
		quiet_thr = (poll_reg == 0) ? 20 : settle_reg / poll_reg + 1;
		if (press_thr > 300) press_thr = 300;
		if (quiet_thr > 300) quiet_thr = 300;
		lvl[0]  = 1'($urandom_range(1, 0));
		lvl[1]  = 1'($urandom_range(1, 0));
		left[0] = 0;
		left[1] = 0;
		for (int n = 0; n < count; n++) begin
			for (int b = 0; b < 2; b++) begin
				if (left[b] == 0) begin
					lvl[b]  = !lvl[b];
					left[b] = run_length(lvl[b] ? press_thr : quiet_thr);
				end
				left[b]--;
			end
			t.user_pressed = lvl[0];
			t.boot_pressed = lvl[1];
			t.manual_mode  = 1'($urandom_range(1, 0));
			t.vent_is_open = 1'($urandom_range(1, 0));
			if ($urandom_range(9, 0) == 0)
				t.user_pressed = 1'($urandom_range(1, 0));
			if ($urandom_range(9, 0) == 0)
				t.boot_pressed = 1'($urandom_range(1, 0));
			send_tick(t);
		end
	endtask

	// A line held pressed since reset must not fire
	task automatic test_unarmed_from_reset();
		set_reg(REG_LONG_PRESS, 16'd1);
		send_ticks(mk_tick(1, 1, 0, 0), 3);
		send_tick(mk_tick(0, 0, 1, 1));
	endtask

	// Long press once per hold, click after quiet time, user long press held off by a click
	task automatic test_long_press_and_click();
		set_reg(REG_POLL_MS, 16'd10);
		set_reg(REG_LONG_PRESS, 16'd25);
		set_reg(REG_CLICK_SETTLE, 16'd15);
		send_ticks(mk_tick(1, 1, 1, 0), 3);
		send_tick(mk_tick(1, 1, 0, 1));
		send_tick(mk_tick(0, 0, 1, 1));
		send_tick(mk_tick(1, 1, 0, 0));
		send_tick(mk_tick(0, 0, 1, 0));
		send_ticks(mk_tick(1, 1, 1, 1), 3);
		send_ticks(mk_tick(0, 0, 0, 1), 2);
	endtask

	// With a zero poll step a press leaves no trace
	task automatic test_zero_poll_step();
		set_reg(REG_POLL_MS, 16'd0);
		send_ticks(mk_tick(1, 1, 1, 1), 2);
		send_tick(mk_tick(0, 0, 1, 0));
		set_reg(REG_POLL_MS, 16'd10);
	endtask

	// Every ring mode, unused codes included, with a steady manual level
	task automatic test_ring_modes();
		set_reg(REG_RING_BLINK, 16'd0);
		for (int m = 0; m < 8; m++) begin
			set_reg(REG_RING_MODE, CFG_DATA_W'(m));
			send_tick(mk_tick(0, 0, $urandom_range(1, 0), $urandom_range(1, 0)));
		end
		set_reg(REG_RING_BLINK, 16'd1);
		set_reg(REG_RING_MODE, CFG_DATA_W'(RING_AUTO));
	endtask

	// Hold results off for a long stretch while items keep coming
	task automatic test_backpressure();
		tx_idle_on     = 1'b0;
		rx_idle_on     = 1'b0;
		holdoff_cycles = 60;
		run_gestures(40);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// User hold keeps growing under a pending click; boot long press fires once per hold
	task automatic test_hold_saturation();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		set_reg(REG_POLL_MS, 16'd255);
		set_reg(REG_LONG_PRESS, 16'd65535);
		set_reg(REG_CLICK_SETTLE, 16'd1);
		send_ticks(mk_tick(0, 0, 0, 0), 2);
		set_reg(REG_CLICK_SETTLE, 16'd65535);
		send_tick(mk_tick(1, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0));
		set_reg(REG_LONG_PRESS, 16'd1);
		send_ticks(mk_tick(1, 1, 1, 0), LONG_HOLD_TICKS);
		send_tick(mk_tick(0, 0, 1, 1));
		set_reg(REG_CLICK_SETTLE, 16'd1000);
		send_ticks(mk_tick(0, 0, 0, 1), 4);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Random gesture scripts, each phase under its own register setting
	task automatic test_random_gestures();
		int poll;
		int step;
		int lp;
		int st;
		logic [CFG_DATA_W-1:0] d;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					poll = 255;
					lp   = 65535;
					st   = 65535;
				end
				1: begin
					poll = 1;
					lp   = 1;
					st   = 1;
				end
				default: begin
					case ($urandom_range(7, 0))
						0:       poll = 0;
						1:       poll = 1;
						2:       poll = 255;
						default: poll = $urandom_range(255, 1);
					endcase
					step = (poll == 0) ? 1 : poll;
					lp   = step * $urandom_range(12, 0) + $urandom_range(step - 1, 0);
					st   = step * $urandom_range(8, 0) + $urandom_range(step - 1, 0);
					if (lp > 65535) lp = 65535;
					if (st > 65535) st = 65535;
				end
			endcase
			// upper data bits are junk for the narrow registers
			d = CFG_DATA_W'($urandom);
			d[2:0] = 3'($urandom_range(7, 0));
			set_reg(REG_RING_MODE, d);
			d = CFG_DATA_W'($urandom);
			set_reg(REG_RING_BLINK, d);
			d = CFG_DATA_W'($urandom);
			d[7:0] = 8'(poll);
			set_reg(REG_POLL_MS, d);
			set_reg(REG_LONG_PRESS, CFG_DATA_W'(lp));
			set_reg(REG_CLICK_SETTLE, CFG_DATA_W'(st));
			set_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_CLICK_SETTLE + 1)),
				CFG_DATA_W'($urandom));
			tx_idle_on = ($urandom_range(3, 0) != 0);
			rx_idle_on = ($urandom_range(3, 0) != 0);
			run_gestures(RANDOM_ITEMS / RANDOM_PHASES);
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		tick_valid     <= 1'b0;
		tick           <= '0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		holdoff_cycles = 0;
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unarmed_from_reset();
		test_long_press_and_click();
		test_zero_poll_step();
		test_ring_modes();
		test_backpressure();
		test_hold_saturation();
		test_random_gestures();

		tick_valid <= 1'b0;
		drain();
		$display("Sent %0d ticks, checked %0d results over %0d register writes, %0d mismatches.",
			ticks_sent, results_checked, reg_writes, mismatches);
		$display("Gestures seen: user long %0d click %0d, boot long %0d click %0d.",
			user_longs, user_clicks, boot_longs, boot_clicks);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
